FILE: hdl/smac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median cost package
// Shared sizes and the command word broadcast to the sorted cell chain.
// ----------------------------------------------------------------------------
package smac_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int COST_BITS   = 22;
   localparam int WIN_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef struct packed {
      logic                   clear;
      logic                   remove;
      logic                   insert;
      logic [SAMPLE_BITS-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: hdl/sliding_median_abs_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median absolute cost
// Keeps the recent samples in a ring RAM and a sorted cell chain, and gives
// the lower median and the sum of absolute deviations of a full window.
// ----------------------------------------------------------------------------
// A result beat is offered once the cost chain has settled in the sum state;
// it waits there while an earlier result has not been taken.
// A new request beat is taken only in the idle state, after the previous one is done.
// Removal and insertion in the cell chain each have their own state, one after the other.
// Reset empties the window and sets the window size to 1; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_median_abs_cost (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [smac_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  wire logic                               req_new_sequence,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [smac_pkg::SAMPLE_BITS-1:0]   rsp_median_value,
   output logic      [smac_pkg::COST_BITS-1:0]     rsp_window_cost,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [smac_pkg::WIN_BITS-1:0]      csr_window_size
);

   localparam int N = smac_pkg::WINDOW_MAX;
   localparam int CNT_BITS = $clog2(N + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_REMOVE, ST_INSERT, ST_MEDIAN, ST_SUM} state_type;

   state_type                        state_ff, state_in;
   logic [smac_pkg::WIN_BITS-1:0]    win_ff, win_in, win_eff, med_pos;
   logic [smac_pkg::WIN_BITS-1:0]    fill_ff, fill_in, fill_start;
   logic [smac_pkg::IDX_BITS-1:0]    wp_ff, wp_in, wp_start, wp_next;
   logic [smac_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in, med_ff, med_in;
   logic                             rem_ff, rem_in, emit_ff, emit_in;
   logic [CNT_BITS-1:0]              cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [smac_pkg::SAMPLE_BITS-1:0] rsp_med_ff, rsp_med_in;
   logic [smac_pkg::COST_BITS-1:0]   rsp_cost_ff, rsp_cost_in;
   logic                             req_beat, csr_beat;
   logic [smac_pkg::SAMPLE_BITS-1:0] ring_rd;
   smac_pkg::cell_cmd_type           cmd;

   logic [smac_pkg::SAMPLE_BITS-1:0] c_value [N];
   logic                             c_valid [N];
   logic                             c_gt    [N];
   logic [smac_pkg::COST_BITS-1:0]   c_acc   [N];

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_beat  = csr_valid && csr_ready;

   assign win_eff = (win_ff == '0) ? smac_pkg::WIN_BITS'(1) :
                    ((win_ff > smac_pkg::WIN_BITS'(N)) ? smac_pkg::WIN_BITS'(N) : win_ff);
   assign med_pos = (win_eff - smac_pkg::WIN_BITS'(1)) >> 1;

   always_comb begin
      fill_start = req_new_sequence ? '0 : fill_ff;
      wp_start   = req_new_sequence ? '0 : wp_ff;
      if ({1'b0, wp_start} >= win_eff) begin
         wp_start = '0;
      end
   end

   assign wp_next = ({1'b0, wp_ff} + smac_pkg::WIN_BITS'(1) >= win_eff) ?
                    '0 : (wp_ff + smac_pkg::IDX_BITS'(1));

   always_comb begin
      cmd.clear  = (req_beat && req_new_sequence) || csr_beat;
      cmd.remove = (state_ff == ST_REMOVE) && rem_ff;
      cmd.insert = (state_ff == ST_INSERT);
      cmd.value  = (state_ff == ST_REMOVE) ? ring_rd : sample_ff;
   end

   smac_ram #(
      .WIDTH (smac_pkg::SAMPLE_BITS),
      .DEPTH (N)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_REMOVE),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (wp_start),
      .rd_data (ring_rd)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      smac_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .median     (med_ff),
         .prev_value ((i == 0) ? '0 : c_value[(i == 0) ? 0 : i - 1]),
         .prev_valid ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i - 1]),
         .prev_gt    ((i == 0) ? 1'b0 : c_gt[(i == 0) ? 0 : i - 1]),
         .prev_acc   ((i == 0) ? '0 : c_acc[(i == 0) ? 0 : i - 1]),
         .next_value ((i == N - 1) ? '0 : c_value[(i == N - 1) ? i : i + 1]),
         .next_valid ((i == N - 1) ? 1'b0 : c_valid[(i == N - 1) ? i : i + 1]),
         .value      (c_value[i]),
         .valid      (c_valid[i]),
         .gt         (c_gt[i]),
         .acc        (c_acc[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      sample_in    = sample_ff;
      med_in       = med_ff;
      rem_in       = rem_ff;
      emit_in      = emit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_med_in   = rsp_med_ff;
      rsp_cost_in  = rsp_cost_ff;
      if (csr_beat) begin
         win_in  = csr_window_size;
         fill_in = '0;
         wp_in   = '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               sample_in = req_sample;
               wp_in     = wp_start;
               rem_in    = (fill_start >= win_eff);
               emit_in   = (fill_start >= win_eff) ||
                           (fill_start + smac_pkg::WIN_BITS'(1) == win_eff);
               fill_in   = (fill_start >= win_eff) ? fill_start :
                           fill_start + smac_pkg::WIN_BITS'(1);
               state_in  = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            wp_in    = wp_next;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            state_in = ST_MEDIAN;
         end
         ST_MEDIAN: begin
            med_in   = c_value[med_pos[smac_pkg::IDX_BITS-1:0]];
            cnt_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (cnt_ff != CNT_BITS'(N)) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end else if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = med_ff;
               rsp_cost_in  = c_acc[N - 1];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= smac_pkg::WIN_BITS'(1);
         fill_ff      <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= 1'b0;
         emit_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         emit_ff      <= emit_in;
         cnt_ff       <= cnt_in;
      end
      sample_ff   <= sample_in;
      med_ff      <= med_in;
      rsp_med_ff  <= rsp_med_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_med_ff;
   assign rsp_window_cost  = rsp_cost_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_eff) else $error("window fill exceeds window size");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat && !csr_beat |=> state_ff == ST_REMOVE) else $error("accepted beat not processed");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && (fill_ff != '0) |-> c_valid[0])
      else $error("chain head empty with samples held");

   a_full_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) && emit_ff |-> c_valid[med_pos[smac_pkg::IDX_BITS-1:0]])
      else $error("median cell empty in a full window");

endmodule
`default_nettype wire

FILE: hdl/smac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/smac_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one sorted entry, shifts with its neighbours on removal and
// insertion, and adds its deviation to the running cost chain.
// ----------------------------------------------------------------------------
module smac_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smac_pkg::cell_cmd_type              cmd,
   input  wire logic [smac_pkg::SAMPLE_BITS-1:0]    median,
   input  wire logic [smac_pkg::SAMPLE_BITS-1:0]    prev_value,
   input  wire logic                                prev_valid,
   input  wire logic                                prev_gt,
   input  wire logic [smac_pkg::COST_BITS-1:0]      prev_acc,
   input  wire logic [smac_pkg::SAMPLE_BITS-1:0]    next_value,
   input  wire logic                                next_valid,
   output logic      [smac_pkg::SAMPLE_BITS-1:0]    value,
   output logic                                     valid,
   output logic                                     gt,
   output logic      [smac_pkg::COST_BITS-1:0]      acc
);

   logic [smac_pkg::SAMPLE_BITS-1:0] value_ff, value_in;
   logic                             valid_ff, valid_in;
   logic [smac_pkg::COST_BITS-1:0]   acc_ff, acc_in;
   logic [smac_pkg::SAMPLE_BITS-1:0] diff;
   logic                             shift_left;

   assign gt         = !valid_ff || (value_ff > cmd.value);
   assign shift_left = valid_ff && (value_ff >= cmd.value);
   assign diff       = (value_ff >= median) ? (value_ff - median) : (median - value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.remove && shift_left) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (cmd.insert && gt) begin
         if (prev_gt) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else begin
            value_in = cmd.value;
            valid_in = 1'b1;
         end
      end
      acc_in = prev_acc + (valid_ff ?
               {{(smac_pkg::COST_BITS - smac_pkg::SAMPLE_BITS){1'b0}}, diff} :
               {smac_pkg::COST_BITS{1'b0}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      acc_ff   <= acc_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign acc   = acc_ff;

endmodule
`default_nettype wire
